// ===== src/wrp_pkg.sv =====
package wrp_pkg;

   // Fixed field widths of the request beat, and the width of the divider's step count.
   localparam int unsigned RND_BITS    = 32;
   localparam int unsigned WEIGHT_BITS = 16;
   localparam int unsigned STEP_BITS   = $clog2(RND_BITS);

   // Action codes carried by a request beat.
   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_DRAW  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Status codes returned in a response beat.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_EMPTY       = 2'd1;
   localparam logic [1:0] ST_ZERO_WEIGHT = 2'd2;
   localparam logic [1:0] ST_FULL        = 2'd3;

   typedef struct packed {
      logic [1:0]               action;
      logic signed [31:0]       new_value;
      logic [WEIGHT_BITS-1:0]   weight;
      logic [RND_BITS-1:0]      random_word;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] picked_value;
      logic [1:0]         status;
   } rsp_type;

   // Handshake between the sequencer and the remainder unit.
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== src/weighted_random_picker_core.sv =====
// Channel    | Ports                          | Handshake
// request    | start, busy, req_item          | beat taken when start && !busy
// response   | rsp_strobe, rsp_data           | one-cycle strobe, cannot be held off
//
// Add, clear, the unused action and a draw on an empty table answer in the cycle after the
// beat is taken. Any other draw runs through the bit-serial remainder unit (one quotient
// bit per cycle), which hands the remainder over as the search target; the draw then walks
// the table entry by entry until the target falls below an entry's running bound.
// The table is a memory with one write port and a registered read port, walked in order.
// Reset clears the entry count and running total; no sweep of the table is needed.
module weighted_random_picker_core #(
   parameter int unsigned MAX_ENTRIES = 16,
   parameter int unsigned VALUE_BITS  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  wrp_pkg::req_type req_item,
   output logic             rsp_strobe,
   output wrp_pkg::rsp_type rsp_data
);
   import wrp_pkg::*;

   localparam int unsigned IDX_BITS   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CNT_BITS   = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned TOTAL_BITS = WEIGHT_BITS + $clog2(MAX_ENTRIES);
   localparam int unsigned ROW_BITS   = VALUE_BITS + TOTAL_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIVIDE,
      S_SEARCH
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [TOTAL_BITS-1:0] target_ff, target_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   div_ctrl_type          div_ctrl;
   div_stat_type          div_stat;
   logic [TOTAL_BITS-1:0] div_rem;

   logic                  wr_en;
   logic [ROW_BITS-1:0]   wr_row;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [ROW_BITS-1:0]   rd_row;
   logic [TOTAL_BITS-1:0] row_bound;
   logic signed [VALUE_BITS-1:0] row_value;
   logic                  last_entry;

   assign busy       = (state_ff != S_IDLE);
   assign row_bound  = rd_row[TOTAL_BITS-1:0];
   assign row_value  = rd_row[ROW_BITS-1:TOTAL_BITS];
   assign last_entry = (CNT_BITS'(idx_ff) + 1'b1) == count_ff;
   assign wr_row     = {req_item.new_value[VALUE_BITS-1:0],
                        total_ff + TOTAL_BITS'(req_item.weight)};

   // The read address runs one entry ahead while walking, and rests on entry zero otherwise.
   assign rd_addr = (state_ff == S_SEARCH) ? idx_ff + 1'b1 : '0;

   // Sequencer: a draw on a filled table divides then walks; all else answers at once.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      target_in     = target_ff;
      idx_in        = idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      div_ctrl      = '0;
      wr_en         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_data_in = '{ok: 1'b0, picked_value: '0, status: ST_OK};
               case (req_item.action)
                  ACT_ADD: begin
                     rsp_strobe_in = 1'b1;
                     if (req_item.weight == '0) begin
                        rsp_data_in.status = ST_ZERO_WEIGHT;
                     end else if (count_ff == CNT_BITS'(MAX_ENTRIES)) begin
                        rsp_data_in.status = ST_FULL;
                     end else begin
                        wr_en          = 1'b1;
                        total_in       = wr_row[TOTAL_BITS-1:0];
                        count_in       = count_ff + 1'b1;
                        rsp_data_in.ok = 1'b1;
                     end
                  end
                  ACT_DRAW: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_data_in.status = ST_EMPTY;
                     end else begin
                        div_ctrl.start = 1'b1;
                        state_in       = S_DIVIDE;
                     end
                  end
                  ACT_CLEAR: begin
                     rsp_strobe_in  = 1'b1;
                     count_in       = '0;
                     total_in       = '0;
                     rsp_data_in.ok = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_DIVIDE: begin
            if (div_stat.done) begin
               target_in = div_rem;
               idx_in    = '0;
               state_in  = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (target_ff < row_bound) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{ok: 1'b1, picked_value: 32'(row_value), status: ST_OK};
               state_in      = S_IDLE;
            end else if (last_entry) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = '{ok: 1'b0, picked_value: '0, status: ST_EMPTY};
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         total_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   wrp_divider #(
      .TOTAL_BITS (TOTAL_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (req_item.random_word),
      .divisor   (total_ff),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   wrp_table #(
      .DEPTH (MAX_ENTRIES),
      .WIDTH (ROW_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (wr_row),
      .rd_addr (rd_addr),
      .rd_data (rd_row)
   );

`ifndef SYNTHESIS
   // The table never holds more entries than it has rows.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_BITS'(MAX_ENTRIES))
      else $error("entry count beyond table depth");
   // Weights are never zero, so an empty table and a zero total go together.
   assert property (@(posedge clock) disable iff (reset) (count_ff == '0) == (total_ff == '0))
      else $error("running total out of step with entry count");
   // The walk stays among written entries.
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == S_SEARCH |-> CNT_BITS'(idx_ff) < count_ff)
      else $error("table walk past last entry");
   // A successful response always carries the ok status.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_strobe_ff && rsp_data_ff.ok |-> rsp_data_ff.status == ST_OK)
      else $error("ok flag with failure status");
   // The divider only runs while a draw is under way.
   assert property (@(posedge clock) disable iff (reset)
                    div_stat.busy |-> state_ff == S_DIVIDE)
      else $error("remainder unit running outside a draw");
`endif

endmodule

// ===== src/wrp_divider.sv =====
module wrp_divider #(
   parameter int unsigned TOTAL_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  wrp_pkg::div_ctrl_type            ctrl,
   input  logic [wrp_pkg::RND_BITS-1:0]     dividend,
   input  logic [TOTAL_BITS-1:0]            divisor,
   output wrp_pkg::div_stat_type            stat,
   output logic [TOTAL_BITS-1:0]            remainder
);
   import wrp_pkg::*;

   logic [TOTAL_BITS-1:0] rem_ff, rem_in;
   logic [RND_BITS-1:0]   quo_ff, quo_in;
   logic [TOTAL_BITS-1:0] div_ff, div_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [TOTAL_BITS:0]   shifted;
   logic [TOTAL_BITS+1:0] diff;

   // One restoring step: bring down the next dividend bit and try to subtract.
   assign shifted = {rem_ff, quo_ff[RND_BITS-1]};
   assign diff    = {1'b0, shifted} - {2'b00, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = diff[TOTAL_BITS+1] ? shifted[TOTAL_BITS-1:0] : diff[TOTAL_BITS-1:0];
         quo_in  = {quo_ff[RND_BITS-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(RND_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign remainder = rem_ff;

`ifndef SYNTHESIS
   // The partial remainder never reaches the divisor while a division runs.
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> rem_ff < div_ff)
      else $error("partial remainder not below divisor");
`endif

endmodule

// ===== src/wrp_table.sv =====
module wrp_table #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned WIDTH = 52
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);
   import wrp_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port and a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
